// File: sv/slpec_pkg.sv
// Package for the segment level and peak checker.
// Holds field widths, register indexes, reset values, result codes and the
// accumulator control struct. No dependencies.
package slpec_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_SEGMENT_DEF = 4096;

  localparam int PEAK_THR_W = 24;
  localparam int POW_THR_W  = 47;
  localparam int COOL_W     = 8;
  localparam int SUM_W      = 58;
  localparam int CFG_W      = 47;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SUM_W-1:0]      SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [PEAK_THR_W-1:0] PEAK_THR_RST = 24'd8388608;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POW_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_LEN = 2'd2;

  typedef enum logic [1:0] {
    CLASS_NORMAL = 2'd0,
    CLASS_UNDER  = 2'd1,
    CLASS_OVER   = 2'd2
  } seg_class_e;

  // Control from the pipeline into the segment accumulator.
  typedef struct packed {
    logic step;  // one item enters the accumulator this cycle
    logic last;  // that item closes the segment
  } acc_ctrl_t;

endpackage

// File: sv/slpec_accum.sv
// Segment accumulator: sum of squares, peak magnitude, sample count and
// overlength flag of the open segment. Uses slpec_pkg.
module slpec_accum #(
  parameter int SAMPLE_BITS = slpec_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SEGMENT = slpec_pkg::MAX_SEGMENT_DEF,
  localparam int CntW = $clog2(MAX_SEGMENT + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slpec_pkg::acc_ctrl_t         ctrl_i,
  input  logic [slpec_pkg::SUM_W-1:0]  sq_i,
  input  logic [SAMPLE_BITS-1:0]       mag_i,
  output logic [slpec_pkg::SUM_W-1:0]  sum_o,
  output logic [SAMPLE_BITS-1:0]       peak_o,
  output logic [CntW-1:0]              count_o,
  output logic                         ovf_o
);
  import slpec_pkg::*;

  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [CntW-1:0]        count_q;
  logic                   ovf_q;
  logic [SUM_W:0]         sum_add;
  logic                   room;

  // Totals with the current item folded in while the segment has room.
  always_comb begin
    room    = count_q < CntW'(MAX_SEGMENT);
    sum_add = {1'b0, sum_q} + {1'b0, sq_i};
    sum_o   = sum_q;
    peak_o  = peak_q;
    count_o = count_q;
    ovf_o   = ovf_q;
    if (room) begin
      sum_o   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      peak_o  = (mag_i > peak_q) ? mag_i : peak_q;
      count_o = count_q + CntW'(1);
    end else begin
      // drop samples past the segment limit
      ovf_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.last) begin
        sum_q   <= '0;
        peak_q  <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_o;
        peak_q  <= peak_o;
        count_q <= count_o;
        ovf_q   <= ovf_o;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SEGMENT))
    else $error("segment count past limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CntW'(MAX_SEGMENT)))
    else $error("overlength flag set on a short segment");

  a_zero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peak_q == '0) |-> (sum_q == '0))
    else $error("nonzero energy with zero peak");

endmodule

// File: sv/segment_level_peak_event_check.sv
// Segment level and peak checker, top level.
// Depends on slpec_pkg and slpec_accum.
//
// Usage: signed samples arrive on the input channel (valid/ready), one item
// per sample, with last_sample_i high on the final sample of a segment. Each
// final sample yields one result item on the output channel: segment class
// (normal, underrange, overload), the impulse latch after that segment, and
// a flag set when the segment ran past MAX_SEGMENT samples (extra samples
// are ignored). Other samples yield no result.
// Throughput: one item per cycle while in_ready_o is high. Path of a result:
// input register, square, accumulate, level product, result register. The
// square and level product stages each hold one multiplier.
// Configuration: cfg_we_i writes register cfg_index_i (0 peak threshold,
// 1 power threshold, 2 cooldown length) at once; write only while idle.
// Reset: all segment totals, cooldown and impulse latch clear, registers take
// their reset values, no result is pending. No clearing pass is needed.
// Stall: when out_ready_i is low the result holds; the pipeline keeps taking
// samples until three more finished segments queue behind it (the last one
// held at the square stage) and one more sample waits in the input register,
// then in_ready_o drops.
module segment_level_peak_event_check #(
  parameter int SAMPLE_BITS = slpec_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SEGMENT = slpec_pkg::MAX_SEGMENT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slpec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slpec_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value_i,
  input  logic                              last_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        segment_class_o,
  output logic                              impulse_seen_o,
  output logic                              segment_overflow_o
);
  import slpec_pkg::*;

  localparam int CntW  = $clog2(MAX_SEGMENT + 1);
  localparam int SqW   = 2 * SAMPLE_BITS;
  localparam int SqExW = (SqW > SUM_W) ? SqW : SUM_W;
  localparam int ProdW = POW_THR_W + CntW;
  localparam int CmpW  = (ProdW > SUM_W) ? ProdW : SUM_W;
  localparam int PkW   = (SAMPLE_BITS > PEAK_THR_W) ? SAMPLE_BITS : PEAK_THR_W;

  // configuration
  logic [PEAK_THR_W-1:0] peak_thr_q;
  logic [POW_THR_W-1:0]  pow_thr_q;
  logic [COOL_W-1:0]     cool_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q <= PEAK_THR_RST;
      pow_thr_q  <= '0;
      cool_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PEAK_THR: peak_thr_q <= cfg_wdata_i[PEAK_THR_W-1:0];
        REG_POW_THR:  pow_thr_q  <= cfg_wdata_i[POW_THR_W-1:0];
        REG_COOL_LEN: cool_len_q <= cfg_wdata_i[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and flow control
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic a_go, b_go, c_go, d_go;
  logic b_free, c_free, d_free, o_free;

  // stage payloads
  logic [SAMPLE_BITS-1:0] a_sample_q;
  logic                   a_last_q;
  logic [SUM_W-1:0]       b_sq_q;
  logic [SAMPLE_BITS-1:0] b_mag_q;
  logic                   b_last_q;
  logic [SUM_W-1:0]       c_sum_q;
  logic [SAMPLE_BITS-1:0] c_peak_q;
  logic [CntW-1:0]        c_count_q;
  logic                   c_ovf_q;
  logic [SUM_W-1:0]       d_sum_q;
  logic [ProdW-1:0]       d_prod_q;
  logic                   d_over_q;
  logic                   d_ovf_q;
  seg_class_e             class_q;
  logic                   imp_out_q;
  logic                   ovf_out_q;

  // persistent state
  logic [COOL_W-1:0] cool_left_q;
  logic              impulse_q;

  assign o_free = !out_valid_q || out_ready_i;
  assign d_go   = d_valid_q && o_free;
  assign d_free = !d_valid_q || o_free;
  assign c_go   = c_valid_q && d_free;
  assign c_free = !c_valid_q || d_free;
  assign b_go   = b_valid_q && (!b_last_q || c_free);
  assign b_free = !b_valid_q || b_go;
  assign a_go   = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || b_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) a_valid_q <= in_valid_i;
      if (b_free)     b_valid_q <= a_go;
      if (c_free)     c_valid_q <= b_go && b_last_q;
      if (d_free)     d_valid_q <= c_go;
      if (o_free)     out_valid_q <= d_go;
    end
  end

  // stage A: input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_sample_q <= sample_value_i;
      a_last_q   <= last_sample_i;
    end
  end

  // stage B: magnitude and clipped square
  logic [SAMPLE_BITS-1:0] mag;
  logic [SqW-1:0]         sq;
  logic [SqExW-1:0]       sq_ex;

  always_comb begin
    mag   = a_sample_q[SAMPLE_BITS-1] ? (~a_sample_q + SAMPLE_BITS'(1)) : a_sample_q;
    sq    = SqW'(mag) * SqW'(mag);
    sq_ex = SqExW'(sq);
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_mag_q  <= mag;
      b_last_q <= a_last_q;
      b_sq_q   <= (sq_ex > SqExW'(SUM_MAX)) ? SUM_MAX : sq_ex[SUM_W-1:0];
    end
  end

  // stage C: accumulate; capture totals on the final sample
  acc_ctrl_t              acc_ctrl;
  logic [SUM_W-1:0]       acc_sum;
  logic [SAMPLE_BITS-1:0] acc_peak;
  logic [CntW-1:0]        acc_count;
  logic                   acc_ovf;

  assign acc_ctrl.step = b_go;
  assign acc_ctrl.last = b_last_q;

  slpec_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SEGMENT(MAX_SEGMENT)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .sq_i    (b_sq_q),
    .mag_i   (b_mag_q),
    .sum_o   (acc_sum),
    .peak_o  (acc_peak),
    .count_o (acc_count),
    .ovf_o   (acc_ovf)
  );

  always_ff @(posedge clk_i) begin
    if (b_go && b_last_q) begin
      c_sum_q   <= acc_sum;
      c_peak_q  <= acc_peak;
      c_count_q <= acc_count;
      c_ovf_q   <= acc_ovf;
    end
  end

  // stage D: level product and peak compare
  always_ff @(posedge clk_i) begin
    if (c_go) begin
      d_sum_q  <= c_sum_q;
      d_prod_q <= ProdW'(pow_thr_q) * ProdW'(c_count_q);
      d_over_q <= (c_peak_q != '0) && (PkW'(c_peak_q) >= PkW'(peak_thr_q));
      d_ovf_q  <= c_ovf_q;
    end
  end

  // result stage: classify, update cooldown and impulse latch
  logic under;
  assign under = CmpW'(d_sum_q) < CmpW'(d_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_left_q <= '0;
      impulse_q   <= 1'b0;
    end else if (d_go) begin
      if (d_over_q) begin
        impulse_q   <= 1'b1;
        cool_left_q <= cool_len_q;
      end else if (cool_left_q != '0) begin
        cool_left_q <= cool_left_q - COOL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_go) begin
      ovf_out_q <= d_ovf_q;
      imp_out_q <= impulse_q || d_over_q;
      priority if (d_over_q) begin
        class_q <= CLASS_OVER;
      end else if (under) begin
        class_q <= CLASS_UNDER;
      end else begin
        class_q <= CLASS_NORMAL;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign segment_class_o    = class_q;
  assign impulse_seen_o     = imp_out_q;
  assign segment_overflow_o = ovf_out_q;

  a_over_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (class_q == CLASS_OVER)) |-> impulse_seen_o)
    else $error("overload result without impulse flag");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && b_valid_q && b_last_q && c_valid_q))
    else $error("input stalled with room in the pipeline");

  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(impulse_q) |-> impulse_q)
    else $error("impulse latch cleared");

endmodule
